@@ rtl/kmcd_pkg.sv @@
// kmcd_pkg: shared types, constants and key map for the key matrix change detector
`timescale 1ns / 1ps

package kmcd_pkg;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 3;
  localparam int CODE_W  = 7;
  localparam int SAMPLE_W = 8;
  localparam int ROM_ROWS = 17;
  localparam int ROM_COLS = 8;
  localparam int ROM_DEPTH = ROM_ROWS * ROM_COLS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic                link_up;
    logic [ROW_W-1:0]    row;
    logic [SAMPLE_W-1:0] column_sample;
  } scan_beat_t;

  typedef struct packed {
    logic [ROW_W-1:0]  event_row;
    logic [COL_W-1:0]  event_column;
    logic [CODE_W-1:0] key_code;
    logic              is_press;
    logic              last;
  } change_beat_t;

  // one row change waiting to be expanded into events
  typedef struct packed {
    logic [ROW_W-1:0]    row;
    logic [SAMPLE_W-1:0] pressed;
    logic [SAMPLE_W-1:0] diff;
  } row_change_t;

  localparam logic [CODE_W-1:0] KEY_ROM [ROM_DEPTH] = '{
    7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67, 7'h68,
    7'h69, 7'h6A, 7'h6B, 7'h6C, 7'h6D, 7'h6E, 7'h6F, 7'h70,
    7'h71, 7'h72, 7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78,
    7'h79, 7'h7A, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h5B, 7'h5D,
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48,
    7'h49, 7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50,
    7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58,
    7'h59, 7'h5A, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h7B, 7'h7D,
    7'h3B, 7'h3A, 7'h27, 7'h22, 7'h2C, 7'h3C, 7'h2E, 7'h3E,
    7'h2F, 7'h3F, 7'h5C, 7'h7C, 7'h60, 7'h7E, 7'h61, 7'h62,
    7'h63, 7'h64, 7'h65, 7'h66, 7'h67, 7'h68, 7'h69, 7'h6A,
    7'h6B, 7'h6C, 7'h6D, 7'h6E, 7'h6F, 7'h70, 7'h71, 7'h72,
    7'h73, 7'h74, 7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A,
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h20, 7'h20, 7'h20, 7'h20, 7'h20, 7'h20
  };

  function automatic logic [CODE_W-1:0] key_code_of(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
    logic [ROW_W+COL_W-1:0] idx;
    idx = {row, col};
    if (row >= ROW_W'(ROM_ROWS)) begin
      return '0;
    end
    return KEY_ROM[idx];
  endfunction

endpackage

@@ rtl/kmcd_if.sv @@
// kmcd_if: valid/ready channel interfaces for row samples and key events
`timescale 1ns / 1ps

interface kmcd_scan_if;
  logic                 valid;
  logic                 ready;
  kmcd_pkg::scan_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kmcd_change_if;
  logic                   valid;
  logic                   ready;
  kmcd_pkg::change_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/key_matrix_change_detector.sv @@
// key_matrix_change_detector: top level of the key matrix change detector
//
//   channel  dir  payload
//   scan     in   link_up, row, column_sample
//   change   out  event_row, event_column, key_code, is_press, last
//
// a sample is taken whenever the row-change queue has room;
// each changed key then leaves on change one beat per cycle while change
// is ready, up to eight changed keys per row
// reset clears the key state map and the queue
// a stalled change port fills the four-entry queue before scan stalls
`timescale 1ns / 1ps

module key_matrix_change_detector #(
  parameter int ROWS = 17,
  parameter int COLS = 8
) (
  input  logic            clk,
  input  logic            rst,
  kmcd_scan_if.sink       scan,
  kmcd_change_if.source   change
);

  logic                  queue_full;
  logic                  queue_empty;
  logic                  push;
  logic                  pop;
  kmcd_pkg::row_change_t push_entry;
  kmcd_pkg::row_change_t pop_entry;

  kmcd_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .scan       (scan),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  kmcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .empty      (queue_empty),
    .pop_entry  (pop_entry)
  );

  kmcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (queue_empty),
    .pop_entry (pop_entry),
    .pop       (pop),
    .change    (change)
  );

endmodule

@@ rtl/kmcd_front.sv @@
// kmcd_front: accepts row samples, keeps the key state map and queues row changes
`timescale 1ns / 1ps

module kmcd_front #(
  parameter int ROWS = 17,
  parameter int COLS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  kmcd_scan_if.sink              scan,
  input  logic                   queue_full,
  output logic                   push,
  output kmcd_pkg::row_change_t  push_entry
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [COLS-1:0] key_down_map [ROWS];

  logic            accept;
  logic            row_ok;
  logic [RW-1:0]   idx;
  logic [COLS-1:0] pressed;
  logic [COLS-1:0] diff;
  logic            update;

  assign scan.ready = !queue_full;
  assign accept     = scan.valid && scan.ready;
  assign row_ok     = {1'b0, scan.data.row} < (kmcd_pkg::ROW_W + 1)'(ROWS);
  assign idx        = row_ok ? scan.data.row[RW-1:0] : '0;
  assign pressed    = ~scan.data.column_sample[COLS-1:0];
  assign diff       = pressed ^ key_down_map[idx];
  assign update     = accept && scan.data.link_up && row_ok;

  assign push               = update && (diff != '0);
  assign push_entry.row     = scan.data.row;
  assign push_entry.pressed = kmcd_pkg::SAMPLE_W'(pressed);
  assign push_entry.diff    = kmcd_pkg::SAMPLE_W'(diff);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        key_down_map[r] <= '0;
      end
    end else if (update) begin
      key_down_map[idx] <= pressed;
    end
  end

endmodule

@@ rtl/kmcd_queue.sv @@
// kmcd_queue: small fifo of row changes between front and back
`timescale 1ns / 1ps

module kmcd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  kmcd_pkg::row_change_t push_entry,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output kmcd_pkg::row_change_t pop_entry
);

  kmcd_pkg::row_change_t mem [kmcd_pkg::QUEUE_DEPTH];

  logic [kmcd_pkg::QPTR_W-1:0] wr_ptr;
  logic [kmcd_pkg::QPTR_W-1:0] rd_ptr;
  logic [kmcd_pkg::QPTR_W:0]   count;

  assign full      = count == (kmcd_pkg::QPTR_W + 1)'(kmcd_pkg::QUEUE_DEPTH);
  assign empty     = count == '0;
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/kmcd_back.sv @@
// kmcd_back: expands one row change into key events, lowest column first
`timescale 1ns / 1ps

module kmcd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  empty,
  input  kmcd_pkg::row_change_t pop_entry,
  output logic                  pop,
  kmcd_change_if.source         change
);

  logic                  cur_valid;
  kmcd_pkg::row_change_t cur;

  logic [kmcd_pkg::COL_W-1:0]    col;
  logic [kmcd_pkg::SAMPLE_W-1:0] rest;
  logic                          fire;
  logic                          done;

  always_comb begin
    col = '0;
    for (int c = kmcd_pkg::SAMPLE_W - 1; c >= 0; c--) begin
      if (cur.diff[c]) begin
        col = kmcd_pkg::COL_W'(c);
      end
    end
  end

  // clear lowest set bit
  assign rest = cur.diff & (cur.diff - 1'b1);
  assign fire = change.valid && change.ready;
  assign done = !cur_valid || (fire && (rest == '0));
  assign pop  = done && !empty;

  assign change.valid             = cur_valid;
  assign change.data.event_row    = cur.row;
  assign change.data.event_column = col;
  assign change.data.key_code     = kmcd_pkg::key_code_of(cur.row, col);
  assign change.data.is_press     = cur.pressed[col];
  assign change.data.last         = rest == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (done) begin
      cur_valid <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_entry;
    end else if (fire) begin
      cur.diff <= rest;
    end
  end

endmodule
